FILE: design/lcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chaser package
// Shared widths, defaults, register indexes and pattern and duty tables.
// ----------------------------------------------------------------------------
package lcpd_pkg;

  localparam int STEPS_PER_MODE_DEF = 8;
  localparam int PWM_PERIOD_DEF     = 13;
  localparam int LEVEL_PERIOD_DEF   = 100;

  localparam int IVL_W   = 11;
  localparam int LED_W   = 8;
  localparam int MODE_W  = 3;
  localparam int LEVEL_W = 3;
  localparam int SAMPLE_W = 8;
  localparam int DUTY_W  = 4;

  localparam logic [IVL_W-1:0] IVL_RESET   = 11'd400;
  localparam logic [IVL_W-1:0] ELAPSED_MAX = 11'd2047;

  localparam logic [DUTY_W-1:0] DUTY_LEVEL_ONE   = 4'd0;
  localparam logic [DUTY_W-1:0] DUTY_LEVEL_TWO   = 4'd3;
  localparam logic [DUTY_W-1:0] DUTY_LEVEL_THREE = 4'd8;
  localparam logic [DUTY_W-1:0] DUTY_LEVEL_FOUR  = 4'd11;

  typedef enum logic [1:0] {
    CFG_IVL_MODE_ONE   = 2'd0,
    CFG_IVL_MODE_TWO   = 2'd1,
    CFG_IVL_MODE_THREE = 2'd2,
    CFG_IVL_MODE_FOUR  = 2'd3
  } cfg_idx_t;

  function automatic logic [LED_W-1:0] pair_rev(input logic [1:0] idx);
    case (idx)
      2'd0:    pair_rev = 8'h18;
      2'd1:    pair_rev = 8'h24;
      2'd2:    pair_rev = 8'h42;
      default: pair_rev = 8'h81;
    endcase
  endfunction

  function automatic logic [LED_W-1:0] pattern_lookup(input logic [1:0] mode,
                                                      input logic [2:0] idx);
    logic [LED_W-1:0] walk;
    logic [LED_W-1:0] pair;
    walk = 8'h01 << idx;
    case (idx[1:0])
      2'd0:    pair = 8'h81;
      2'd1:    pair = 8'h42;
      2'd2:    pair = 8'h24;
      default: pair = 8'h18;
    endcase
    case (mode)
      2'd0:    pattern_lookup = walk;
      2'd1:    pattern_lookup = 8'h80 >> idx;
      2'd2:    pattern_lookup = pair;
      default: pattern_lookup = pair_rev(idx[1:0]);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] duty_lookup(input logic [LEVEL_W-1:0] level);
    case (level)
      3'd1:    duty_lookup = DUTY_LEVEL_ONE;
      3'd2:    duty_lookup = DUTY_LEVEL_TWO;
      3'd3:    duty_lookup = DUTY_LEVEL_THREE;
      3'd4:    duty_lookup = DUTY_LEVEL_FOUR;
      default: duty_lookup = DUTY_LEVEL_ONE;
    endcase
  endfunction

endpackage

FILE: design/lcpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chaser channel interfaces
// Valid/ready channels for tick items and for result items.
// ----------------------------------------------------------------------------
interface lcpd_in_if
  import lcpd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                run_toggle;
  logic [SAMPLE_W-1:0] light_sample;

  modport source (output valid, output run_toggle, output light_sample, input ready);
  modport sink   (input valid, input run_toggle, input light_sample, output ready);
endinterface

interface lcpd_out_if
  import lcpd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LED_W-1:0]   led_drive;
  logic [MODE_W-1:0]  pattern_mode;
  logic               is_running;
  logic [LEVEL_W-1:0] bright_level;

  modport source (output valid, output led_drive, output pattern_mode,
                  output is_running, output bright_level, input ready);
  modport sink   (input valid, input led_drive, input pattern_mode,
                  input is_running, input bright_level, output ready);
endinterface

FILE: design/led_chaser_pwm_dimmer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chaser with PWM dimming
// Each input item is one millisecond tick carrying a run toggle and a light
// sample. The block steps four LED chase patterns, latches a brightness level
// periodically and gates the LEDs with a PWM phase counter.
//
// Channels: in_ch takes tick items, out_ch returns one result item per tick.
// A transfer happens when valid and ready are both high. cfg_we, cfg_index and
// cfg_wdata write the four step intervals; the user must do so only while the
// block is idle, which the block itself does not enforce. A tick is registered
// at its transfer; throughput is one tick per cycle unless out_ch stalls, set
// by the single state update between the input and result registers.
// Reset (rst_n low at a clock edge) stops the chaser, clears all counters,
// the pattern and the level, and sets every interval to 400 ticks.
// When the receiver stalls, the result is held and one further tick waits in
// the input register; in_ch.ready then falls until the result is taken.
// ----------------------------------------------------------------------------
module led_chaser_pwm_dimmer_top
  import lcpd_pkg::*;
#(
  parameter int STEPS_PER_MODE = STEPS_PER_MODE_DEF,
  parameter int PWM_PERIOD     = PWM_PERIOD_DEF,
  parameter int LEVEL_PERIOD   = LEVEL_PERIOD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lcpd_in_if.sink          in_ch,
  lcpd_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [IVL_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(STEPS_PER_MODE);
  localparam int PW = $clog2(PWM_PERIOD);
  localparam int LW = $clog2(LEVEL_PERIOD + 1);

  logic                in_valid_r;
  logic                toggle_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                advance;

  logic [IVL_W-1:0]    interval_r [4];
  logic [IVL_W-1:0]    elapsed_r, elapsed_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                running_r, running_nxt;
  logic [LED_W-1:0]    pattern_r, pattern_nxt;
  logic [PW-1:0]       phase_r, phase_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [LW-1:0]       divider_r, divider_nxt;

  logic                out_valid_r;
  logic [LED_W-1:0]    led_r;

  logic [SW+2:0]       step_wide;
  logic [SW:0]         step_inc;
  logic [PW:0]         phase_inc;
  logic [LW:0]         divider_inc;
  logic [IVL_W-1:0]    elapsed_inc;
  logic [LED_W-1:0]    gated;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      toggle_r <= in_ch.run_toggle;
      sample_r <= in_ch.light_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        interval_r[k] <= IVL_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IVL_MODE_ONE:   interval_r[0] <= cfg_wdata;
        CFG_IVL_MODE_TWO:   interval_r[1] <= cfg_wdata;
        CFG_IVL_MODE_THREE: interval_r[2] <= cfg_wdata;
        CFG_IVL_MODE_FOUR:  interval_r[3] <= cfg_wdata;
        default:            interval_r[0] <= interval_r[0];
      endcase
    end
  end

  always_comb begin
    elapsed_inc  = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 11'd1;
    elapsed_nxt  = elapsed_inc;
    mode_nxt     = mode_r;
    pattern_nxt  = pattern_r;
    running_nxt  = running_r;
    step_nxt     = step_r;
    level_nxt    = level_r;

    if (toggle_r) begin
      if (running_r) begin
        pattern_nxt = '0;
      end else begin
        mode_nxt = 2'd0;
      end
      running_nxt = !running_r;
    end

    if (divider_r == '0) begin
      level_nxt = {1'b0, sample_r[7:6]} + 3'd1;
    end
    divider_inc = {1'b0, divider_r} + 1'b1;
    divider_nxt = (divider_inc >= (LW+1)'(LEVEL_PERIOD)) ? '0 : divider_inc[LW-1:0];

    step_wide = {3'b000, step_r};
    step_inc  = {1'b0, step_r} + 1'b1;
    if (running_nxt && (elapsed_inc >= interval_r[mode_nxt])) begin
      elapsed_nxt = '0;
      pattern_nxt = pattern_lookup(mode_nxt, step_wide[2:0]);
      if (step_inc >= (SW+1)'(STEPS_PER_MODE)) begin
        step_nxt = '0;
        mode_nxt = mode_nxt + 2'd1;
      end else begin
        step_nxt = step_inc[SW-1:0];
      end
    end

    phase_inc = {1'b0, phase_r} + 1'b1;
    phase_nxt = (phase_inc >= (PW+1)'(PWM_PERIOD)) ? '0 : phase_inc[PW-1:0];

    gated = ({4'b0000, phase_nxt} <= {{PW{1'b0}}, duty_lookup(level_nxt)}) ?
            pattern_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      step_r      <= '0;
      mode_r      <= '0;
      running_r   <= 1'b0;
      pattern_r   <= '0;
      phase_r     <= '0;
      level_r     <= '0;
      divider_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        elapsed_r <= elapsed_nxt;
        step_r    <= step_nxt;
        mode_r    <= mode_nxt;
        running_r <= running_nxt;
        pattern_r <= pattern_nxt;
        phase_r   <= phase_nxt;
        level_r   <= level_nxt;
        divider_r <= divider_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_r <= gated;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_drive    = led_r;
  assign out_ch.pattern_mode = {1'b0, mode_r} + 3'd1;
  assign out_ch.is_running   = running_r;
  assign out_ch.bright_level = level_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("Processed tick did not produce a result.");

  a_dark_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (pattern_r == '0))
    else $error("LED pattern not cleared while stopped.");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= 3'd4)
    else $error("Brightness level out of range.");

  a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(mode_r) && $stable(step_r) && $stable(phase_r)))
    else $error("Chaser state moved without a processed tick.");

endmodule

FILE: tb/lcpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chaser result checker
// Watches the tick and result channels and the interval write port. Every
// tick transfer is run through a local model of the chaser, and the result it
// predicts is queued. Every result transfer is compared field by field with
// the oldest queued prediction. The mismatch count and the number of
// predictions still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module lcpd_checker
  import lcpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lcpd_in_if               in_ch,
  lcpd_out_if              out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [IVL_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [LED_W-1:0]   led_drive;
    logic [MODE_W-1:0]  pattern_mode;
    logic               is_running;
    logic [LEVEL_W-1:0] bright_level;
  } chaser_result_t;

  localparam logic [LED_W-1:0] CHASE_TAB [0:31] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01,
    8'h81, 8'h42, 8'h24, 8'h18, 8'h81, 8'h42, 8'h24, 8'h18,
    8'h18, 8'h24, 8'h42, 8'h81, 8'h18, 8'h24, 8'h42, 8'h81
  };

  logic [IVL_W-1:0]   step_ivl [4];
  logic [IVL_W-1:0]   elapsed;
  logic [2:0]         step_idx;
  logic [1:0]         mode_idx;
  logic               running;
  logic [LED_W-1:0]   leds;
  logic [DUTY_W-1:0]  pwm_phase;
  logic [LEVEL_W-1:0] level;
  logic [6:0]         level_div;

  chaser_result_t predicted_results[$];
  int             reports;

  function automatic logic [DUTY_W-1:0] duty_for(input logic [LEVEL_W-1:0] lvl);
    case (lvl)
      3'd2:    duty_for = DUTY_LEVEL_TWO;
      3'd3:    duty_for = DUTY_LEVEL_THREE;
      3'd4:    duty_for = DUTY_LEVEL_FOUR;
      default: duty_for = DUTY_LEVEL_ONE;
    endcase
  endfunction

  function automatic chaser_result_t advance_tick(input logic toggle,
                                                  input logic [SAMPLE_W-1:0] sample);
    chaser_result_t r;
    if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
    if (toggle) begin
      if (running) leds = '0;
      else mode_idx = 2'd0;
      running = !running;
    end
    if (level_div == 7'd0) level = {1'b0, sample[7:6]} + 3'd1;
    if (level_div == 7'(LEVEL_PERIOD_DEF - 1)) level_div = 7'd0;
    else level_div = level_div + 7'd1;
    if (running && elapsed >= step_ivl[mode_idx]) begin
      elapsed = '0;
      leds = CHASE_TAB[{mode_idx, step_idx}];
      if (step_idx == 3'(STEPS_PER_MODE_DEF - 1)) begin
        step_idx = 3'd0;
        mode_idx = mode_idx + 2'd1;
      end else begin
        step_idx = step_idx + 3'd1;
      end
    end
    if (pwm_phase == DUTY_W'(PWM_PERIOD_DEF - 1)) pwm_phase = '0;
    else pwm_phase = pwm_phase + 1'b1;
    r.led_drive    = (pwm_phase <= duty_for(level)) ? leds : '0;
    r.pattern_mode = {1'b0, mode_idx} + 3'd1;
    r.is_running   = running;
    r.bright_level = level;
    return r;
  endfunction

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (reports < 40) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
    reports++;
  endtask

  always @(posedge clk) begin
    chaser_result_t want;
    int             bad;
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) step_ivl[k] = IVL_RESET;
      elapsed   = '0;
      step_idx  = '0;
      mode_idx  = '0;
      running   = 1'b0;
      leds      = '0;
      pwm_phase = '0;
      level     = '0;
      level_div = '0;
      reports   = 0;
      predicted_results.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      bad = 0;
      if (cfg_we) step_ivl[cfg_index] = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          if (reports < 40) begin
            $display("%0t: result with no tick outstanding, expected none, actual %h/%0d/%0d/%0d",
                     $time, out_ch.led_drive, out_ch.pattern_mode, out_ch.is_running,
                     out_ch.bright_level);
          end
          reports++;
          bad++;
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.led_drive !== want.led_drive) begin
            report_field("led_drive", want.led_drive, out_ch.led_drive);
            bad++;
          end
          if (out_ch.pattern_mode !== want.pattern_mode) begin
            report_field("pattern_mode", want.pattern_mode, out_ch.pattern_mode);
            bad++;
          end
          if (out_ch.is_running !== want.is_running) begin
            report_field("is_running", want.is_running, out_ch.is_running);
            bad++;
          end
          if (out_ch.bright_level !== want.bright_level) begin
            report_field("bright_level", want.bright_level, out_ch.bright_level);
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(advance_tick(in_ch.run_toggle, in_ch.light_sample));
      end
      mismatches <= mismatches + bad;
      pending    <= predicted_results.size();
    end
  end

endmodule

FILE: tb/led_chaser_pwm_dimmer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chaser testbench top
// Drives tick items and interval writes into the chaser, applies random
// back-pressure on the result channel and gives the verdict. A short directed
// sequence covers start, stop, zero and one-tick intervals; random phases
// then vary the intervals, toggle density and idle patterns, and a final
// phase stops a running chaser and restarts it with the longest intervals.
// ----------------------------------------------------------------------------
module led_chaser_pwm_dimmer_top_tb
  import lcpd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [IVL_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent;
  int toggles_sent;
  int settings_written;
  int quiet_cycles;
  bit running_guess;

  lcpd_in_if  in_if ();
  lcpd_out_if out_if ();

  led_chaser_pwm_dimmer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcpd_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] edges [8] = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191,
                                       8'd192, 8'd255};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 7)];
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IVL_W-1:0] pick_interval();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return IVL_W'($urandom_range(0, 12));
    if (roll == 7) return '0;
    if (roll == 8) return IVL_W'($urandom_range(400, 1200));
    return IVL_W'($urandom_range(0, 2047));
  endfunction

  task automatic send_tick(input logic toggle, input logic [SAMPLE_W-1:0] sample);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.run_toggle   <= toggle;
    in_if.light_sample <= sample;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ticks_sent++;
    if (toggle) begin
      toggles_sent++;
      running_guess = !running_guess;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_intervals(input logic [IVL_W-1:0] one, input logic [IVL_W-1:0] two,
                               input logic [IVL_W-1:0] three,
                               input logic [IVL_W-1:0] four);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IVL_MODE_ONE;
    cfg_wdata <= one;
    @(negedge clk);
    cfg_index <= CFG_IVL_MODE_TWO;
    cfg_wdata <= two;
    @(negedge clk);
    cfg_index <= CFG_IVL_MODE_THREE;
    cfg_wdata <= three;
    @(negedge clk);
    cfg_index <= CFG_IVL_MODE_FOUR;
    cfg_wdata <= four;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  task automatic run_phase(input int ticks, input int toggle_pm);
    repeat (ticks) send_tick($urandom_range(0, 999) < toggle_pm, pick_sample());
  endtask

  initial begin
    int toggle_pm;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.run_toggle   = 1'b0;
    in_if.light_sample = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_IVL_MODE_ONE;
    cfg_wdata          = '0;
    send_idle_pct      = 22;
    recv_idle_pct      = 63;
    ticks_sent         = 0;
    toggles_sent       = 0;
    settings_written   = 0;
    running_guess      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_tick(1'b0, 8'd255);
    send_tick(1'b1, 8'd0);
    send_tick(1'b1, 8'd128);

    set_intervals(11'd0, 11'd1, 11'd0, 11'd2047);
    send_tick(1'b1, 8'd64);
    for (int k = 0; k < 18; k++) send_tick(1'b0, pick_sample());
    send_tick(1'b1, 8'd191);
    send_tick(1'b1, 8'd63);

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p % 3)
        0:       toggle_pm = 400;
        1:       toggle_pm = 15;
        default: toggle_pm = 3;
      endcase
      if (p == 4) begin
        set_intervals(11'd400, 11'd1200, 11'd1200, 11'd400);
        run_phase(420, 2);
      end else begin
        set_intervals(pick_interval(), pick_interval(), pick_interval(), pick_interval());
        run_phase(140, toggle_pm);
      end
    end

    set_intervals(11'd2047, 11'd2047, 11'd2047, 11'd2047);
    if (running_guess) send_tick(1'b1, pick_sample());
    repeat (30) send_tick(1'b0, pick_sample());
    send_tick(1'b1, pick_sample());
    repeat (20) send_tick(1'b0, pick_sample());

    drain();
    $display("Ran %0d ticks with %0d run toggles over %0d interval settings.",
             ticks_sent, toggles_sent, settings_written);
    $display("Both channels were stalled at random and intervals ran from zero to maximum.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
